// ===== hw/rtl/sorted_list_insert_delete_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted list insert/delete: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication
`define SLID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list: same-cycle check failed");

// next-cycle implication
`define SLID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list: next-cycle check failed");

`endif

// ===== hw/rtl/slid_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert/delete: package
// Widths, operation codes, controller states and command bundle.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int DATA_W       = 32;
  localparam int CNT_W        = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
  } ctl_t;

endpackage

// ===== hw/rtl/slid_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert/delete: controller
// Two-state sequencer: capture and compare, then update and emit result.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_defines.svh"

module slid_ctrl
  import slid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output ctl_t cmd,
  output logic out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = 1'b0;
    cmd.apply = 1'b0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        busy     = 1'b0;
      end
      ST_UPDATE: cmd.apply = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.apply;
    end
  end

  assign out_valid = out_valid_r;

  `SLID_ASSERT_NEXT(a_load_to_update, cmd.load, state_r == ST_UPDATE)
  `SLID_ASSERT_NEXT(a_update_strobe, state_r == ST_UPDATE, out_valid_r && state_r == ST_IDLE)
  `SLID_ASSERT_SAME(a_strobe_not_busy, out_valid_r, !busy)

endmodule

// ===== hw/rtl/slid_dpath.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert/delete: datapath
// Row of value cells with per-cell compare flags and neighbor shifting.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_defines.svh"

module slid_dpath
  import slid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     cmd,
  input  logic                     in_operation,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_success,
  output logic [CNT_W-1:0]         out_count
);

  localparam int HW = $clog2(CAPACITY + 1);
  localparam logic [HW-1:0] CAP_H = HW'(CAPACITY);

  logic signed [DATA_W-1:0] e_r   [CAPACITY];
  logic signed [DATA_W-1:0] e_nxt [CAPACITY];
  logic signed [DATA_W-1:0] val_r;
  op_t                      op_r;
  logic [CAPACITY-1:0]      lt_r, hit_r, bnd_v;
  logic [HW-1:0]            held_r, held_nxt;
  logic                     out_success_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     full, found, ins_ok, del_ok;

  assign full   = (held_r == CAP_H);
  assign found  = |(bnd_v & hit_r);
  assign ins_ok = (op_r == OP_INSERT) && !full;
  assign del_ok = (op_r == OP_DELETE) && found;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev, nbr_up;
    logic                     bnd;
    logic                     live;

    if (g == 0) begin : g_first
      assign prev = val_r;
      assign bnd  = !lt_r[0];
    end else begin : g_rest
      assign prev = e_r[g-1];
      assign bnd  = !lt_r[g] && lt_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign nbr_up = e_r[g];
    end else begin : g_mid
      assign nbr_up = e_r[g+1];
    end

    assign bnd_v[g] = bnd;
    assign live     = (HW'(g) < held_r);

    always_comb begin
      e_nxt[g] = e_r[g];
      if (cmd.apply && !lt_r[g]) begin
        if (ins_ok) begin
          e_nxt[g] = bnd ? val_r : prev;
        end else if (del_ok) begin
          e_nxt[g] = nbr_up;
        end
      end
    end

    always_ff @(posedge clk) begin
      e_r[g] <= e_nxt[g];
      if (cmd.load) begin
        lt_r[g]  <= live && (e_r[g] < in_value);
        hit_r[g] <= live && (e_r[g] == in_value);
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (cmd.apply) begin
      if (ins_ok) begin
        held_nxt = held_r + HW'(1);
      end else if (del_ok) begin
        held_nxt = held_r - HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
      op_r  <= op_t'(in_operation);
    end
    if (cmd.apply) begin
      out_success_r <= ins_ok || del_ok;
      out_count_r   <= CNT_W'(held_nxt);
    end
  end

  assign out_success = out_success_r;
  assign out_count   = out_count_r;

  `SLID_ASSERT_SAME(a_held_max, 1'b1, held_r <= CAP_H)
  `SLID_ASSERT_NEXT(a_insert_count, cmd.apply && ins_ok, held_r == $past(held_r) + 1'b1)
  `SLID_ASSERT_NEXT(a_fail_hold, cmd.apply && !ins_ok && !del_ok, held_r == $past(held_r))

endmodule

// ===== hw/rtl/sorted_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert/delete: top level
// Bounded ascending store of signed values with insert and delete commands.
// ----------------------------------------------------------------------------
// Each command runs in order: the cycle of the start transfer captures the
// operand and compares it against every held cell at once, the next cycle
// shifts the cells and updates the count. busy is high during that update
// cycle; the result appears on out_success/out_count with out_valid for one
// cycle right after it, and the receiver cannot stall it. A new start is taken
// in the same cycle as that result, so commands are taken one at a time.
// Inserts into a full store and deletes of a missing value report failure
// and leave the store unchanged.
module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic                     out_success,
  output logic [CNT_W-1:0]         out_count
);

  ctl_t cmd;

  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  slid_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_success  (out_success),
    .out_count    (out_count)
  );

endmodule

// ===== tb/sorted_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list insert/delete: testbench
// Sends insert and delete commands and checks each result against a local
// model of the bounded ascending store: success flag and count per command.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb
  import slid_pkg::*;
();

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic             success;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  op_t                      in_operation = OP_INSERT;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_success;
  logic [CNT_W-1:0]         out_count;

  int       store_vals [CAPACITY_DEF];
  int       store_len;
  outcome_t pending_outcomes[$];
  int       mismatches;
  int       idle_cycles;

  always #10 clk = ~clk;

  sorted_list_insert_delete #(
    .CAPACITY (CAPACITY_DEF)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_success  (out_success),
    .out_count    (out_count)
  );

  // store model: ascending, new value in front of equal ones
  function automatic outcome_t apply_command(op_t op, int value);
    outcome_t res;
    int pos;
    pos = 0;
    res.success = 1'b0;
    if (op == OP_INSERT) begin
      if (store_len < CAPACITY_DEF) begin
        while (pos < store_len && store_vals[pos] < value) pos++;
        for (int i = store_len; i > pos; i--) store_vals[i] = store_vals[i-1];
        store_vals[pos] = value;
        store_len++;
        res.success = 1'b1;
      end
    end else begin
      while (pos < store_len && store_vals[pos] != value) pos++;
      if (pos < store_len) begin
        for (int i = pos; i + 1 < store_len; i++) store_vals[i] = store_vals[i+1];
        store_len--;
        res.success = 1'b1;
      end
    end
    res.count = store_len[CNT_W-1:0];
    return res;
  endfunction

  task automatic send_command(op_t op, int value);
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= value;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(apply_command(op, value));
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return int'($urandom_range(0, 15)) - 8;
    if (sel < 7 && store_len > 0) return store_vals[$urandom_range(0, store_len - 1)];
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic test_directed_cases();
    send_command(OP_DELETE, 5);
    send_command(OP_INSERT, 32'h7FFF_FFFF);
    send_command(OP_INSERT, 32'h8000_0000);
    send_command(OP_INSERT, 0);
    send_command(OP_INSERT, -1);
    send_command(OP_INSERT, 0);
    for (int i = 0; i < 11; i++) send_command(OP_INSERT, 100 - 7 * i);
    send_command(OP_INSERT, 3);
    send_command(OP_DELETE, 12345);
    send_command(OP_DELETE, 32'h8000_0000);
    send_command(OP_DELETE, 32'h7FFF_FFFF);
    send_command(OP_DELETE, 0);
    send_command(OP_DELETE, 0);
    send_command(OP_DELETE, 0);
    drain_results();
  endtask

  // segments with shifting insert bias walk the store between empty and full
  task automatic test_random_mix(int segments, int seg_len);
    int  ins_pct;
    bit  quiet;
    op_t op;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(0, 4))
        0: ins_pct = 90;
        1: ins_pct = 70;
        2: ins_pct = 50;
        3: ins_pct = 30;
        default: ins_pct = 10;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len; k++) begin
        if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 19));
        if ($urandom_range(0, 99) == 0) drain_results();
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
        send_command(op, pick_value());
      end
    end
    drain_results();
  endtask

  task automatic test_back_to_back(int n);
    for (int k = 0; k < n; k++)
      send_command($urandom_range(0, 1) ? OP_DELETE : OP_INSERT, pick_value());
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: success %0b count %0d", out_success, out_count);
      end else begin
        outcome_t exp_res;
        exp_res = pending_outcomes.pop_front();
        if (out_success !== exp_res.success || out_count !== exp_res.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected success %0b count %0d, got success %0b count %0d",
                     exp_res.success, exp_res.count, out_success, out_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    store_len   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_mix(17, 50);
    test_back_to_back(150);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/slid_pkg.sv
hw/rtl/slid_ctrl.sv
hw/rtl/slid_dpath.sv
hw/rtl/sorted_list_insert_delete.sv
tb/sorted_list_insert_delete_tb.sv
